[rtl/core/dpbp_pkg.sv]
// shared types, widths and constants of the depth pixel back-projection unit
package dpbp_pkg;

  localparam int unsigned DEPTH_W     = 16;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned FOCAL_W     = 20;
  localparam int unsigned CENTER_W    = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned DEN_W       = 30;
  localparam int unsigned QUO_W       = 31;
  localparam int unsigned PLOW_W      = 15;
  localparam int unsigned Z_W         = 23;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam int unsigned MAX_COLUMNS_DEF = 4096;
  localparam int unsigned MAX_ROWS_DEF    = 4096;

  // front stages, one stage per quotient bit, output register
  localparam int unsigned PRE_STG = 3;
  localparam int unsigned NSTG    = PRE_STG + QUO_W + 1;

  localparam logic [9:0] MM_PER_M = 10'd1000;

  // z = floor(depth * 65536 / 1000) = (depth * Z_RECIP) >> Z_SHIFT
  localparam logic [32:0] Z_RECIP = 33'd4398046512;
  localparam int unsigned Z_SHIFT = 26;
  localparam int unsigned ZP_W    = DEPTH_W + 33;

  localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = 20'd6400;
  localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = 20'd6400;
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd3840;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_t;

  // per-item flags that ride alongside the divider
  typedef struct packed {
    logic           sgn_x;
    logic           sgn_y;
    logic           sat_x;
    logic           sat_y;
    logic           pv;
    logic [Z_W-1:0] z;
  } side_t;

  // divisor 1000 * focal, a zero focal counts as one
  function automatic logic [DEN_W-1:0] den_of(input logic [FOCAL_W-1:0] f);
    logic [FOCAL_W-1:0] f1;
    f1 = (f == '0) ? FOCAL_W'(1) : f;
    return DEN_W'(DEN_W'(f1) * DEN_W'(MM_PER_M));
  endfunction

endpackage

[rtl/core/depth_pixel_back_projection_unit.sv]
// top level: pinhole back-projection of a depth pixel stream to 3-d points
//
// in_*  : one depth pixel per item (depth_mm, column, row), one item per clock at most
// out_* : one point per item (point_x, point_y, point_z in q16 metres, point_valid on tuser)
// cfg_* : focal lengths and principal point in 1/16 pixel, written while no item is in flight
// throughput: one item per cycle unless a receiver stall fills every stage; each axis runs
//   through a 31-stage divider that resolves one quotient bit per stage, next to three
//   front stages and an output register
// a depth of zero gives point_valid low and all coordinates zero
// reset (rst_n low at a clock edge) empties the pipeline and loads the default intrinsics
// when the receiver stalls, items keep moving into empty stages behind the output
//   register; in_tready falls only once every stage holds an item
module depth_pixel_back_projection_unit #(
  parameter int unsigned MAX_COLUMNS = dpbp_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = dpbp_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dpbp_pkg::IN_TDATA_W-1:0]   in_tdata,   // depth_mm, column, row
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dpbp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // point_x, point_y, point_z, zero pad
  output logic                              out_tuser,  // point_valid
  input  logic                              cfg_we,
  input  logic [dpbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpbp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dpbp_pkg::*;

  localparam logic [COORD_W:0]   ColLim  = (COORD_W+1)'(MAX_COLUMNS);
  localparam logic [COORD_W-1:0] ColLast = COORD_W'(MAX_COLUMNS - 1);
  localparam logic [COORD_W:0]   RowLim  = (COORD_W+1)'(MAX_ROWS);
  localparam logic [COORD_W-1:0] RowLast = COORD_W'(MAX_ROWS - 1);

  // configuration
  logic [DEN_W-1:0]    den_x_r, den_y_r;
  logic [CENTER_W-1:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_x_r <= den_of(FOCAL_X_RST);
      den_y_r <= den_of(FOCAL_Y_RST);
      cx_r    <= CENTER_X_RST;
      cy_r    <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FOCAL_X:  den_x_r <= den_of(cfg_wdata);
        CFG_FOCAL_Y:  den_y_r <= den_of(cfg_wdata);
        CFG_CENTER_X: cx_r    <= cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y: cy_r    <= cfg_wdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and stage loads
  logic [NSTG-1:0] v_r, v_nxt, ld;

  for (genvar i = 0; i < NSTG; i++) begin : g_ld
    assign ld[i] = out_tready | ~(&v_r[NSTG-1:i]);
  end

  always_comb begin
    v_nxt[0] = ld[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = ld[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = v_r[NSTG-1];

  // stage 0: clamp and offset from the principal point
  logic [DEPTH_W-1:0] in_depth;
  logic [COORD_W-1:0] in_col, in_row, col_c, row_c;
  logic [MAG_W:0]     dx, dy;

  assign in_depth = in_tdata[DEPTH_W-1:0];
  assign in_col   = in_tdata[DEPTH_W +: COORD_W];
  assign in_row   = in_tdata[DEPTH_W+COORD_W +: COORD_W];

  always_comb begin
    col_c = ({1'b0, in_col} >= ColLim) ? ColLast : in_col;
    row_c = ({1'b0, in_row} >= RowLim) ? RowLast : in_row;
    dx    = {1'b0, col_c, 4'b0000} - {1'b0, cx_r};
    dy    = {1'b0, row_c, 4'b0000} - {1'b0, cy_r};
  end

  logic [DEPTH_W-1:0] depth0_r;
  logic [MAG_W-1:0]   magx0_r, magy0_r;
  logic               sgnx0_r, sgny0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      depth0_r <= in_depth;
      sgnx0_r  <= dx[MAG_W];
      sgny0_r  <= dy[MAG_W];
      magx0_r  <= dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      magy0_r  <= dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    end
  end

  // stage 1: products
  logic [PROD_W-1:0] px1_r, py1_r;
  logic [ZP_W-1:0]   zp1_r;
  logic              sgnx1_r, sgny1_r, pv1_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      px1_r   <= PROD_W'(magx0_r) * PROD_W'(depth0_r);
      py1_r   <= PROD_W'(magy0_r) * PROD_W'(depth0_r);
      zp1_r   <= ZP_W'(depth0_r) * ZP_W'(Z_RECIP);
      sgnx1_r <= sgnx0_r;
      sgny1_r <= sgny0_r;
      pv1_r   <= (depth0_r != '0);
    end
  end

  // stage 2: overflow check and divider seed
  logic [DEN_W-1:0]  remx2_r, remy2_r, hix, hiy;
  logic [PLOW_W-1:0] lox2_r, loy2_r;
  side_t             side2_r;

  assign hix = DEN_W'(px1_r[PROD_W-1:PLOW_W]);
  assign hiy = DEN_W'(py1_r[PROD_W-1:PLOW_W]);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      remx2_r       <= hix;
      remy2_r       <= hiy;
      lox2_r        <= px1_r[PLOW_W-1:0];
      loy2_r        <= py1_r[PLOW_W-1:0];
      side2_r.sgn_x <= sgnx1_r;
      side2_r.sgn_y <= sgny1_r;
      side2_r.sat_x <= (hix >= den_x_r);
      side2_r.sat_y <= (hiy >= den_y_r);
      side2_r.pv    <= pv1_r;
      side2_r.z     <= zp1_r[Z_SHIFT +: Z_W];
    end
  end

  // divider stages
  logic [QUO_W-1:0] qx, qy;

  dpbp_div u_div_x (
    .clk    (clk),
    .ld     (ld[PRE_STG +: QUO_W]),
    .rem_in (remx2_r),
    .low_in (lox2_r),
    .den    (den_x_r),
    .quo    (qx)
  );

  dpbp_div u_div_y (
    .clk    (clk),
    .ld     (ld[PRE_STG +: QUO_W]),
    .rem_in (remy2_r),
    .low_in (loy2_r),
    .den    (den_y_r),
    .quo    (qy)
  );

  side_t side_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (ld[PRE_STG+j]) begin
        side_r[j] <= (j == 0) ? side2_r : side_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // output register: sign and saturation
  side_t            side_o;
  logic [OUT_W-1:0] x_nxt, y_nxt;
  logic [OUT_W-1:0] out_x_r, out_y_r;
  logic [Z_W-1:0]   out_z_r;
  logic             out_pv_r;

  assign side_o = side_r[QUO_W-1];

  always_comb begin
    if (side_o.sat_x) begin
      x_nxt = side_o.sgn_x ? SAT_NEG : SAT_POS;
    end else begin
      x_nxt = side_o.sgn_x ? OUT_W'(-{1'b0, qx}) : {1'b0, qx};
    end
    if (side_o.sat_y) begin
      y_nxt = side_o.sgn_y ? SAT_NEG : SAT_POS;
    end else begin
      y_nxt = side_o.sgn_y ? OUT_W'(-{1'b0, qy}) : {1'b0, qy};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NSTG-1]) begin
      out_x_r  <= x_nxt;
      out_y_r  <= y_nxt;
      out_z_r  <= side_o.z;
      out_pv_r <= side_o.pv;
    end
  end

  assign out_tdata = {1'b0, out_z_r, out_y_r, out_x_r};
  assign out_tuser = out_pv_r;

endmodule

[rtl/core/dpbp_div.sv]
// pipelined restoring divider, one quotient bit per stage
module dpbp_div (
  input  logic                         clk,
  input  logic [dpbp_pkg::QUO_W-1:0]   ld,
  input  logic [dpbp_pkg::DEN_W-1:0]   rem_in,
  input  logic [dpbp_pkg::PLOW_W-1:0]  low_in,
  input  logic [dpbp_pkg::DEN_W-1:0]   den,
  output logic [dpbp_pkg::QUO_W-1:0]   quo
);
  import dpbp_pkg::*;

  logic [DEN_W-1:0]  rem_r [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];
  logic [PLOW_W-1:0] low_r [PLOW_W-1];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stg
    logic [DEN_W-1:0] rem_prev;
    logic [QUO_W-1:0] quo_prev;
    logic             nbit;
    logic [DEN_W:0]   trial;
    logic             qbit;
    logic [DEN_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign rem_prev = rem_in;
      assign quo_prev = '0;
      assign nbit     = low_in[PLOW_W-1];
    end else begin : g_next
      assign rem_prev = rem_r[j-1];
      assign quo_prev = quo_r[j-1];
      if (j < PLOW_W) begin : g_bit
        assign nbit = low_r[j-1][PLOW_W-1];
      end else begin : g_zero
        assign nbit = 1'b0;
      end
    end

    if (j < PLOW_W - 1) begin : g_low
      logic [PLOW_W-1:0] low_prev;
      logic [PLOW_W-1:0] low_nxt;
      if (j == 0) begin : g_lin
        assign low_prev = low_in;
      end else begin : g_lreg
        assign low_prev = low_r[j-1];
      end
      assign low_nxt = {low_prev[PLOW_W-2:0], 1'b0};
      always_ff @(posedge clk) begin
        if (ld[j]) begin
          low_r[j] <= low_nxt;
        end
      end
    end

    always_comb begin
      trial   = {rem_prev, nbit};
      qbit    = (trial >= {1'b0, den});
      rem_nxt = qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo_nxt = {quo_prev[QUO_W-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

[rtl/core/dpbp_chk.sv]
// port-level checker for the depth pixel back-projection unit, bound to the top level
module dpbp_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [dpbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dpbp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser
);
  import dpbp_pkg::*;

  localparam logic [Z_W-1:0] Z_MAX = 23'd4294901;

  logic [Z_W-1:0] z_w;
  assign z_w = out_tdata[2*OUT_W +: Z_W];

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("item on output right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output item changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tready || !out_tvalid) |-> in_tready)
    else $error("input blocked while the output side can move");

  a_no_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("point without depth carries nonzero coordinates");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> z_w != '0 && z_w <= Z_MAX)
    else $error("z out of range for a measured depth");

endmodule

bind depth_pixel_back_projection_unit dpbp_chk u_dpbp_chk (.*);

[tb/depth_pixel_back_projection_unit_test.sv]
`timescale 1ns / 100ps
// self-checking stream testbench of the depth pixel back-projection unit
module depth_pixel_back_projection_unit_test;
  import dpbp_pkg::*;

  localparam int unsigned PIPE_LAT    = 34;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 135;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [DEPTH_W-1:0] depth_mm;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [Z_W-1:0]   z;
    logic             valid;
  } point_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // depth_mm, column, row
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // point_x, point_y, point_z, zero pad
  logic                   out_tuser;        // point_valid
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  logic [FOCAL_W-1:0]  focal_x_q  = FOCAL_X_RST;
  logic [FOCAL_W-1:0]  focal_y_q  = FOCAL_Y_RST;
  logic [CENTER_W-1:0] center_x_q = CENTER_X_RST;
  logic [CENTER_W-1:0] center_y_q = CENTER_Y_RST;

  pixel_t      pixel_queue[$];
  point_t      point_queue[$];
  pixel_t      cur_pixel;
  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;
  int unsigned hold_left   = 0;
  int unsigned points_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors      = 0;
  logic        send_burst  = 1'b0;
  logic        recv_burst  = 1'b0;

  depth_pixel_back_projection_unit uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  function automatic logic [OUT_W-1:0] axis_q16(longint offset, logic [DEPTH_W-1:0] depth,
                                                logic [FOCAL_W-1:0] focal);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned quo;
    logic [OUT_W-1:0] low;
    mag = (offset < 0) ? -offset : offset;
    den = 64'd1000 * ((focal == '0) ? 64'd1 : 64'(focal));
    quo = (mag * 64'(depth) * 64'd65536) / den;
    low = quo[OUT_W-1:0];
    if (offset < 0)
      return (quo >= 64'h8000_0000) ? SAT_NEG : ~low + 32'd1;
    return (quo > 64'h7fff_ffff) ? SAT_POS : low;
  endfunction

  function automatic point_t project_pixel(pixel_t p);
    point_t pt;
    logic [COORD_W:0] col;
    logic [COORD_W:0] row;
    pt  = '0;
    col = (COORD_W+1)'(p.column);
    row = (COORD_W+1)'(p.row);
    if (col >= MAX_COLUMNS_DEF) col = (COORD_W+1)'(MAX_COLUMNS_DEF - 1);
    if (row >= MAX_ROWS_DEF) row = (COORD_W+1)'(MAX_ROWS_DEF - 1);
    if (p.depth_mm != '0) begin
      pt.x     = axis_q16(longint'(col) * 16 - longint'(center_x_q), p.depth_mm, focal_x_q);
      pt.y     = axis_q16(longint'(row) * 16 - longint'(center_y_q), p.depth_mm, focal_y_q);
      pt.z     = Z_W'((64'(p.depth_mm) * 64'd65536) / 64'd1000);
      pt.valid = 1'b1;
    end
    return pt;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    case ($urandom_range(0, 9))
      0:       p.depth_mm = '0;
      1:       p.depth_mm = $urandom_range(0, 1) ? 16'hffff : 16'd1;
      2:       p.depth_mm = 16'($urandom_range(1, 1000));
      default: p.depth_mm = 16'($urandom);
    endcase
    if ($urandom_range(0, 15) == 0) p.column = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    else p.column = 12'($urandom);
    if ($urandom_range(0, 15) == 0) p.row = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    else p.row = 12'($urandom);
    return p;
  endfunction

  function automatic logic [FOCAL_W-1:0] random_focal();
    if ($urandom_range(0, 3) == 0) return FOCAL_W'($urandom_range(16, 1048575));
    return FOCAL_W'($urandom_range(16, 20000));
  endfunction

  task automatic report_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic set_intrinsics(logic [FOCAL_W-1:0] fx, logic [FOCAL_W-1:0] fy,
                                logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy);
    write_reg(CFG_FOCAL_X, fx);
    write_reg(CFG_FOCAL_Y, fy);
    write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
    write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
    @(posedge clk);
    cfg_we     <= 1'b0;
    focal_x_q  = fx;
    focal_y_q  = fy;
    center_x_q = cx;
    center_y_q = cy;
  endtask

  task automatic queue_pixel(logic [DEPTH_W-1:0] depth, logic [COORD_W-1:0] col,
                             logic [COORD_W-1:0] row);
    pixel_queue.push_back('{row: row, column: col, depth_mm: depth});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_tvalid || point_queue.size() != 0);
    repeat (PIPE_LAT + 6) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) point_queue.push_back(project_pixel(cur_pixel));
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        cur_pixel = pixel_queue.pop_front();
        in_tdata  <= cur_pixel;
        in_tvalid <= 1'b1;
        send_gap  <= send_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0) send_burst <= ~send_burst;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    point_t got;
    point_t want;
    int unsigned gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[31:0];
        got.y     = out_tdata[63:32];
        got.z     = out_tdata[64 +: Z_W];
        got.valid = out_tuser;
        if (point_queue.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected item, expected none, actual %h", $time, got);
        end else begin
          want = point_queue.pop_front();
          report_field("point_x", want.x, got.x);
          report_field("point_y", want.y, got.y);
          report_field("point_z", OUT_W'(want.z), OUT_W'(got.z));
          report_field("point_valid", OUT_W'(want.valid), OUT_W'(got.valid));
        end
        points_seen <= points_seen + 1;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (out_tvalid && out_tready && (points_seen == 380 || points_seen == 660)) begin
        out_tready <= 1'b0;
        hold_left  <= LONG_HOLD;
      end else if (out_tvalid && out_tready) begin
        gap = recv_burst ? 0 : $urandom_range(0, 13);
        out_tready <= (gap == 0);
        recv_gap   <= (gap == 0) ? 0 : gap - 1;
        if ($urandom_range(0, 39) == 0) recv_burst <= ~recv_burst;
      end else if (recv_gap != 0) begin
        out_tready <= 1'b0;
        recv_gap   <= recv_gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset intrinsics, principal point at column 320, row 240
    queue_pixel(16'd0, 12'd0, 12'd0);
    queue_pixel(16'd0, 12'hfff, 12'hfff);
    queue_pixel(16'd1, 12'd0, 12'd0);
    queue_pixel(16'hffff, 12'd0, 12'd0);
    queue_pixel(16'hffff, 12'hfff, 12'hfff);
    queue_pixel(16'd1000, 12'd320, 12'd240);
    queue_pixel(16'd1000, 12'd321, 12'd239);
    queue_pixel(16'hffff, 12'd320, 12'hfff);
    queue_pixel(16'd12345, 12'hfff, 12'd0);
    wait_idle();

    // tiny and zero focal lengths, saturation both ways
    set_intrinsics(20'd16, 20'd0, 16'h0000, 16'hffff);
    queue_pixel(16'hffff, 12'hfff, 12'd0);
    queue_pixel(16'hffff, 12'd0, 12'hfff);
    queue_pixel(16'd0, 12'hfff, 12'd0);
    queue_pixel(16'd1, 12'd1, 12'hfff);
    queue_pixel(16'd2, 12'hfff, 12'hfff);
    queue_pixel(16'hffff, 12'hfff, 12'hfff);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_intrinsics(20'hfffff, 20'hfffff, 16'hffff, 16'h0000);
        1:       set_intrinsics(20'd16, 20'd16, 16'h0000, 16'h0000);
        2:       set_intrinsics(20'd0, 20'd0, 16'hffff, 16'hffff);
        default: set_intrinsics(random_focal(), random_focal(), 16'($urandom), 16'($urandom));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) pixel_queue.push_back(random_pixel());
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
